@@ src/ppai_pkg.sv @@
// ----------------------------------------------------------------------------
// Pose arc integrator package
// Shared fixed-point constants, the CORDIC arctangent table and state codes.
// ----------------------------------------------------------------------------
`default_nettype none

package ppai_pkg;

    // Angles are signed Q4.28.
    localparam logic signed [31:0] PI_Q      = 32'sd843314857;
    localparam logic signed [31:0] HALF_PI_Q = 32'sd421657428;
    localparam logic        [31:0] TWO_PI_Q  = 32'd1686629714;

    // CORDIC start value (gain compensated, Q2.30).
    localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;

    // Rotation count; counts above 32 behave as 32.
    localparam int CORDIC_ITERATIONS = 24;
    localparam int CORDIC_STEPS      = (CORDIC_ITERATIONS > 32) ? 32 : CORDIC_ITERATIONS;

    // Reset value of the straight-line threshold register.
    localparam logic [15:0] THRESHOLD_RESET = 16'd1;

    // Arctangent of 2^-i in Q4.28.
    function automatic logic [31:0] atan_q28(input logic [4:0] idx);
        logic [31:0] v;
        begin
            case (idx)
                5'd0:    v = 32'd210828714;
                5'd1:    v = 32'd124459457;
                5'd2:    v = 32'd67103136;
                5'd3:    v = 32'd33381290;
                5'd4:    v = 32'd16755422;
                5'd5:    v = 32'd8385879;
                5'd6:    v = 32'd4193963;
                5'd7:    v = 32'd2097109;
                5'd8:    v = 32'd1048571;
                5'd9:    v = 32'd524287;
                5'd10:   v = 32'd262144;
                5'd11:   v = 32'd131072;
                5'd12:   v = 32'd65536;
                5'd13:   v = 32'd32768;
                5'd14:   v = 32'd16384;
                5'd15:   v = 32'd8192;
                5'd16:   v = 32'd4096;
                5'd17:   v = 32'd2048;
                5'd18:   v = 32'd1024;
                5'd19:   v = 32'd512;
                5'd20:   v = 32'd256;
                5'd21:   v = 32'd128;
                5'd22:   v = 32'd64;
                5'd23:   v = 32'd32;
                5'd24:   v = 32'd16;
                5'd25:   v = 32'd8;
                5'd26:   v = 32'd4;
                5'd27:   v = 32'd2;
                5'd28:   v = 32'd1;
                default: v = 32'd0;
            endcase
            atan_q28 = v;
        end
    endfunction

    // Sequencer state codes.
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_HWRAP = 4'd1;
    localparam logic [3:0] S_M_WDT = 4'd2;
    localparam logic [3:0] S_WRAP1 = 4'd3;
    localparam logic [3:0] S_COR0  = 4'd4;
    localparam logic [3:0] S_M_VDT = 4'd5;
    localparam logic [3:0] S_M_DC  = 4'd6;
    localparam logic [3:0] S_M_DS  = 4'd7;
    localparam logic [3:0] S_COR1  = 4'd8;
    localparam logic [3:0] S_M_VS  = 4'd9;
    localparam logic [3:0] S_DIV_X = 4'd10;
    localparam logic [3:0] S_M_VC  = 4'd11;
    localparam logic [3:0] S_DIV_Y = 4'd12;
    localparam logic [3:0] S_OUT   = 4'd13;

endpackage

`default_nettype wire

@@ src/ppai_mul.sv @@
// ----------------------------------------------------------------------------
// Serial signed multiplier
// 64 x 32 bit two's complement product, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ppai_mul import ppai_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [63:0] i_a,
    input  wire logic [31:0] i_b,
    output logic             o_done,
    output logic [95:0]      o_prod
);

    logic [63:0] r_a;
    logic [64:0] r_acc;
    logic [31:0] r_mb;
    logic [4:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [65:0] addend;
    logic [65:0] a_ext;
    logic [65:0] sum;

    // The top multiplier bit carries negative weight.
    always_comb begin
        a_ext = {{2{r_a[63]}}, r_a};
        if (!r_mb[0]) begin
            addend = 66'd0;
        end else if (r_cnt == 5'd31) begin
            addend = ~a_ext + 66'd1;
        end else begin
            addend = a_ext;
        end
        sum = {r_acc[64], r_acc} + addend;
    end

    // Add and shift right, product low bits collect in r_mb.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 5'd0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_a    <= i_a;
                r_acc  <= 65'd0;
                r_mb   <= i_b;
                r_cnt  <= 5'd0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_acc <= sum[65:1];
                r_mb  <= {sum[0], r_mb[31:1]};
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = {r_acc[63:0], r_mb};

endmodule

`default_nettype wire

@@ src/ppai_div.sv @@
// ----------------------------------------------------------------------------
// Serial signed divider
// 64 / 32 bit restoring division, one quotient bit per cycle, truncating.
// ----------------------------------------------------------------------------
`default_nettype none

module ppai_div import ppai_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [63:0] i_num,
    input  wire logic [31:0] i_den,
    output logic             o_done,
    output logic [63:0]      o_quot
);

    logic [63:0] r_q;
    logic [31:0] r_d;
    logic [31:0] r_rem;
    logic        r_neg;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [32:0] trial;
    logic [32:0] diff;
    logic        ge;

    // One restoring step.
    always_comb begin
        trial = {r_rem, r_q[63]};
        diff  = trial - {1'b0, r_d};
        ge    = (trial >= {1'b0, r_d});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 6'd0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_neg  <= i_num[63] ^ i_den[31];
                r_q    <= i_num[63] ? (~i_num + 64'd1) : i_num;
                r_d    <= i_den[31] ? (~i_den + 32'd1) : i_den;
                r_rem  <= 32'd0;
                r_cnt  <= 6'd0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem <= ge ? diff[31:0] : trial[31:0];
                r_q   <= {r_q[62:0], ge};
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd63) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_neg ? (~r_q + 64'd1) : r_q;

endmodule

`default_nettype wire

@@ src/ppai_wrap.sv @@
// ----------------------------------------------------------------------------
// Serial angle wrap
// Reduces a wide Q4.28 angle into (-pi, pi], one dividend bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ppai_wrap import ppai_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [63:0] i_a,
    output logic             o_done,
    output logic [31:0]      o_angle
);

    logic [63:0] r_m;
    logic [30:0] r_rem;
    logic        r_neg;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [63:0] shifted;
    logic [31:0] trial;
    logic [31:0] diff;
    logic        ge;
    logic [31:0] u;

    // Shift in one magnitude bit and reduce modulo two pi.
    always_comb begin
        shifted = i_a + {{32{PI_Q[31]}}, PI_Q};
        trial   = {r_rem, r_m[63]};
        diff    = trial - TWO_PI_Q;
        ge      = (trial >= TWO_PI_Q);
    end

    // Map the remainder into (0, 2pi] and remove the pi offset.
    always_comb begin
        if (r_neg && (r_rem != 31'd0)) begin
            u = TWO_PI_Q - {1'b0, r_rem};
        end else if (r_rem == 31'd0) begin
            u = TWO_PI_Q;
        end else begin
            u = {1'b0, r_rem};
        end
        o_angle = u - PI_Q;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 6'd0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_neg  <= shifted[63];
                r_m    <= shifted[63] ? (~shifted + 64'd1) : shifted;
                r_rem  <= 31'd0;
                r_cnt  <= 6'd0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem <= ge ? diff[30:0] : trial[30:0];
                r_m   <= {r_m[62:0], 1'b0};
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd63) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;

endmodule

`default_nettype wire

@@ src/ppai_cordic.sv @@
// ----------------------------------------------------------------------------
// Iterative CORDIC
// Rotation-mode sine and cosine of a wrapped Q4.28 angle, one step per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ppai_cordic import ppai_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [31:0] i_angle,
    output logic             o_done,
    output logic [33:0]      o_cos,
    output logic [33:0]      o_sin
);

    logic signed [33:0] r_x;
    logic signed [33:0] r_y;
    logic signed [31:0] r_z;
    logic               r_neg;
    logic [4:0]         r_i;
    logic               r_busy;
    logic               r_done;
    logic signed [31:0] a;
    logic signed [33:0] dx;
    logic signed [33:0] dy;
    logic signed [31:0] t;

    always_comb begin
        a  = $signed(i_angle);
        dx = r_y >>> r_i;
        dy = r_x >>> r_i;
        t  = $signed(atan_q28(r_i));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_i    <= 5'd0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                // Fold the outer half planes onto the inner one.
                if (a > HALF_PI_Q) begin
                    r_z   <= a - PI_Q;
                    r_neg <= 1'b1;
                end else if (a < -HALF_PI_Q) begin
                    r_z   <= a + PI_Q;
                    r_neg <= 1'b1;
                end else begin
                    r_z   <= a;
                    r_neg <= 1'b0;
                end
                r_x    <= CORDIC_GAIN_Q30;
                r_y    <= 34'sd0;
                r_i    <= 5'd0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (!r_z[31]) begin
                    r_x <= r_x - dx;
                    r_y <= r_y + dy;
                    r_z <= r_z - t;
                end else begin
                    r_x <= r_x + dx;
                    r_y <= r_y - dy;
                    r_z <= r_z + t;
                end
                r_i <= r_i + 5'd1;
                if (r_i == 5'(CORDIC_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_cos  = r_neg ? -r_x : r_x;
    assign o_sin  = r_neg ? -r_y : r_y;

endmodule

`default_nettype wire

@@ src/planar_pose_arc_integrator_core.sv @@
// ----------------------------------------------------------------------------
// Planar pose arc integrator
// Odometry pose update from a body twist, straight or constant-curvature arc.
// ----------------------------------------------------------------------------
// Usage:
// Requests enter on the input channel (i_in_valid / o_in_ready) and one result
// per request leaves on the output channel (o_out_valid / i_out_ready). The
// threshold register is written through its own channel (i_cfg_valid /
// o_cfg_ready), which is always ready; write it only while the block is idle.
// One request is processed at a time by a sequencer over shared serial units:
// a bit-serial multiplier, a restoring divider, a serial angle wrap and an
// iterative CORDIC. A set pose runs a wrap; a rejected step goes straight to
// the output; a straight step runs a multiply, a wrap, a CORDIC and three
// multiplies; an arc step runs a multiply, a wrap, two CORDICs and two
// multiply and divide pairs. Without stalls a new request can be taken in the
// cycle after the result is registered, so requests never overlap. If the
// receiver stalls, the following result waits in the sequencer until the
// register frees. Reset clears pose and twist to zero and the threshold to one.
// ----------------------------------------------------------------------------
`default_nettype none

module planar_pose_arc_integrator_core import ppai_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [15:0] i_cfg_data,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic        i_operation,
    input  wire logic [31:0] i_linear_speed,
    input  wire logic [31:0] i_angular_rate,
    input  wire logic [31:0] i_step_time,
    input  wire logic [31:0] i_new_x,
    input  wire logic [31:0] i_new_y,
    input  wire logic [31:0] i_new_heading,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [31:0]      o_pos_x,
    output logic [31:0]      o_pos_y,
    output logic [30:0]      o_heading,
    output logic [31:0]      o_twist_linear,
    output logic [31:0]      o_twist_angular,
    output logic             o_step_accepted
);

    logic [3:0]         r_state;
    logic [15:0]        r_thr;
    logic [31:0]        r_v;
    logic [31:0]        r_w;
    logic [31:0]        r_dt;
    logic [31:0]        r_x;
    logic [31:0]        r_y;
    logic signed [31:0] r_h;
    logic [31:0]        r_h1;
    logic [31:0]        r_lin;
    logic [31:0]        r_ang;
    logic [33:0]        r_c0;
    logic [33:0]        r_s0;
    logic [34:0]        r_dc;
    logic [47:0]        r_d;
    logic               r_acc;

    logic               r_mul_go;
    logic [63:0]        r_ma;
    logic [31:0]        r_mb;
    logic               r_div_go;
    logic [63:0]        r_dnum;
    logic               r_wrap_go;
    logic [63:0]        r_wa;
    logic               r_cor_go;
    logic [31:0]        r_ca;

    logic               r_ov;
    logic [31:0]        r_o_x;
    logic [31:0]        r_o_y;
    logic [30:0]        r_o_h;
    logic [31:0]        r_o_lin;
    logic [31:0]        r_o_ang;
    logic               r_o_acc;

    logic               mul_done;
    logic [95:0]        mul_p;
    logic               div_done;
    logic [63:0]        div_q;
    logic               wrap_done;
    logic [31:0]        wrap_h;
    logic               cor_done;
    logic [33:0]        cor_c;
    logic [33:0]        cor_s;

    logic               in_take;
    logic [31:0]        w_abs;
    logic               straight;
    logic [63:0]        dth_sum;
    logic [63:0]        head_sum;
    logic [63:0]        d_sum;
    logic [61:0]        lin_prod;
    logic [63:0]        q_rnd;
    logic [34:0]        ds;
    logic [34:0]        dc;

    // Shared serial units.
    ppai_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_mul_go),
        .i_a     (r_ma),
        .i_b     (r_mb),
        .o_done  (mul_done),
        .o_prod  (mul_p)
    );

    ppai_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_go),
        .i_num   (r_dnum),
        .i_den   (r_w),
        .o_done  (div_done),
        .o_quot  (div_q)
    );

    ppai_wrap u_wrap (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_wrap_go),
        .i_a     (r_wa),
        .o_done  (wrap_done),
        .o_angle (wrap_h)
    );

    ppai_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_cor_go),
        .i_angle (r_ca),
        .o_done  (cor_done),
        .o_cos   (cor_c),
        .o_sin   (cor_s)
    );

    // Handshakes.
    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == S_IDLE);
    assign in_take     = i_in_valid && o_in_ready;

    // Datapath glue between the serial units.
    always_comb begin
        w_abs    = r_w[31] ? (~r_w + 32'd1) : r_w;
        straight = (r_w == 32'd0) || (w_abs < {16'd0, r_thr});
        dth_sum  = mul_p[63:0] + 64'd8;
        head_sum = {{32{r_h[31]}}, r_h} + {{4{dth_sum[63]}}, dth_sum[63:4]};
        d_sum    = mul_p[63:0] + 64'h8000;
        lin_prod = mul_p[61:0] + 62'h2000_0000;
        q_rnd    = div_q + 64'h2000;
        ds       = {cor_s[33], cor_s} - {r_s0[33], r_s0};
        dc       = {cor_c[33], cor_c} - {r_c0[33], r_c0};
    end

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_thr     <= THRESHOLD_RESET;
            r_x       <= 32'd0;
            r_y       <= 32'd0;
            r_h       <= 32'sd0;
            r_lin     <= 32'd0;
            r_ang     <= 32'd0;
            r_acc     <= 1'b0;
            r_mul_go  <= 1'b0;
            r_div_go  <= 1'b0;
            r_wrap_go <= 1'b0;
            r_cor_go  <= 1'b0;
            r_ov      <= 1'b0;
        end else begin
            // Launch strobes last one cycle; the unit is busy while they clear.
            if (r_mul_go) begin
                r_mul_go <= 1'b0;
            end
            if (r_div_go) begin
                r_div_go <= 1'b0;
            end
            if (r_wrap_go) begin
                r_wrap_go <= 1'b0;
            end
            if (r_cor_go) begin
                r_cor_go <= 1'b0;
            end

            if (i_cfg_valid) begin
                r_thr <= i_cfg_data;
            end

            // The output register empties when the receiver takes it, unless a new result is loaded.
            if (r_ov && i_out_ready && (r_state != S_OUT)) begin
                r_ov <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_take) begin
                        r_v  <= i_linear_speed;
                        r_w  <= i_angular_rate;
                        r_dt <= i_step_time;
                        if (i_operation) begin
                            r_x       <= i_new_x;
                            r_y       <= i_new_y;
                            r_wa      <= {{32{i_new_heading[31]}}, i_new_heading};
                            r_wrap_go <= 1'b1;
                            r_state   <= S_HWRAP;
                        end else if (i_step_time[31] || (i_step_time == 32'd0)) begin
                            r_acc   <= 1'b0;
                            r_state <= S_OUT;
                        end else begin
                            r_ma     <= {{32{i_angular_rate[31]}}, i_angular_rate};
                            r_mb     <= i_step_time;
                            r_mul_go <= 1'b1;
                            r_state  <= S_M_WDT;
                        end
                    end
                end
                S_HWRAP: begin
                    if (wrap_done) begin
                        r_h     <= wrap_h;
                        r_acc   <= 1'b0;
                        r_state <= S_OUT;
                    end
                end
                S_M_WDT: begin
                    // New heading before wrapping.
                    if (mul_done) begin
                        r_wa      <= head_sum;
                        r_wrap_go <= 1'b1;
                        r_state   <= S_WRAP1;
                    end
                end
                S_WRAP1: begin
                    if (wrap_done) begin
                        r_h1     <= wrap_h;
                        r_ca     <= r_h;
                        r_cor_go <= 1'b1;
                        r_state  <= S_COR0;
                    end
                end
                S_COR0: begin
                    if (cor_done) begin
                        r_c0 <= cor_c;
                        r_s0 <= cor_s;
                        if (straight) begin
                            r_ma     <= {{32{r_v[31]}}, r_v};
                            r_mb     <= r_dt;
                            r_mul_go <= 1'b1;
                            r_state  <= S_M_VDT;
                        end else begin
                            r_ca     <= r_h1;
                            r_cor_go <= 1'b1;
                            r_state  <= S_COR1;
                        end
                    end
                end
                S_M_VDT: begin
                    // Travel distance, rounded to Q32.16.
                    if (mul_done) begin
                        r_d      <= d_sum[63:16];
                        r_ma     <= {{16{d_sum[63]}}, d_sum[63:16]};
                        r_mb     <= r_c0[31:0];
                        r_mul_go <= 1'b1;
                        r_state  <= S_M_DC;
                    end
                end
                S_M_DC: begin
                    if (mul_done) begin
                        r_x      <= r_x + lin_prod[61:30];
                        r_ma     <= {{16{r_d[47]}}, r_d};
                        r_mb     <= r_s0[31:0];
                        r_mul_go <= 1'b1;
                        r_state  <= S_M_DS;
                    end
                end
                S_M_DS: begin
                    if (mul_done) begin
                        r_y     <= r_y + lin_prod[61:30];
                        r_h     <= r_h1;
                        r_lin   <= r_v;
                        r_ang   <= r_w;
                        r_acc   <= 1'b1;
                        r_state <= S_OUT;
                    end
                end
                S_COR1: begin
                    if (cor_done) begin
                        r_dc     <= dc;
                        r_ma     <= {{29{ds[34]}}, ds};
                        r_mb     <= r_v;
                        r_mul_go <= 1'b1;
                        r_state  <= S_M_VS;
                    end
                end
                S_M_VS: begin
                    if (mul_done) begin
                        r_dnum   <= mul_p[63:0];
                        r_div_go <= 1'b1;
                        r_state  <= S_DIV_X;
                    end
                end
                S_DIV_X: begin
                    if (div_done) begin
                        r_x      <= r_x + q_rnd[45:14];
                        r_ma     <= {{29{r_dc[34]}}, r_dc};
                        r_mb     <= r_v;
                        r_mul_go <= 1'b1;
                        r_state  <= S_M_VC;
                    end
                end
                S_M_VC: begin
                    if (mul_done) begin
                        r_dnum   <= mul_p[63:0];
                        r_div_go <= 1'b1;
                        r_state  <= S_DIV_Y;
                    end
                end
                S_DIV_Y: begin
                    if (div_done) begin
                        r_y     <= r_y - q_rnd[45:14];
                        r_h     <= r_h1;
                        r_lin   <= r_v;
                        r_ang   <= r_w;
                        r_acc   <= 1'b1;
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    // Hand the result over once the output register is free.
                    if (!r_ov || i_out_ready) begin
                        r_ov    <= 1'b1;
                        r_o_x   <= r_x;
                        r_o_y   <= r_y;
                        r_o_h   <= r_h[30:0];
                        r_o_lin <= r_lin;
                        r_o_ang <= r_ang;
                        r_o_acc <= r_acc;
                        r_state <= S_IDLE;
                    end else begin
                        r_ov <= 1'b1;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid     = r_ov;
    assign o_pos_x         = r_o_x;
    assign o_pos_y         = r_o_y;
    assign o_heading       = r_o_h;
    assign o_twist_linear  = r_o_lin;
    assign o_twist_angular = r_o_ang;
    assign o_step_accepted = r_o_acc;

    // The stored heading always stays inside (-pi, pi].
    a_heading_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_h > -PI_Q) && (r_h <= PI_Q))
        else $error("stored heading left the wrapped range");

    // Only one serial unit is launched at a time.
    a_one_launch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({r_mul_go, r_div_go, r_wrap_go, r_cor_go}))
        else $error("two serial units launched together");

    // An accepted request always leaves the idle state.
    a_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_take |=> (r_state != S_IDLE))
        else $error("request accepted but sequencer stayed idle");

endmodule

`default_nettype wire

@@ sim/tb_planar_pose_arc_integrator_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the planar pose arc integrator
// Drives set-pose and integrate requests with random gaps and output stalls.
// It also writes the straight-line threshold between phases. A predictor
// written here computes every expected pose, and each result is checked field
// by field against the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_planar_pose_arc_integrator_core;
    import ppai_pkg::*;

    localparam logic OP_STEP     = 1'b0;
    localparam logic OP_SET_POSE = 1'b1;
    localparam int   SETTLE_CYCLES = 400;
    localparam int   HOLD_CYCLES   = 1500;

    typedef struct packed {
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [30:0] heading;
        logic [31:0] twist_linear;
        logic [31:0] twist_angular;
        logic        step_accepted;
    } pose_report_t;

    typedef struct packed {
        logic        operation;
        logic [31:0] linear_speed;
        logic [31:0] angular_rate;
        logic [31:0] step_time;
        logic [31:0] new_x;
        logic [31:0] new_y;
        logic [31:0] new_heading;
    } odo_request_t;

    // Block ports; the inputs are all known from time zero.
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [15:0] i_cfg_data = '0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic        i_operation = 1'b0;
    logic [31:0] i_linear_speed = '0;
    logic [31:0] i_angular_rate = '0;
    logic [31:0] i_step_time = '0;
    logic [31:0] i_new_x = '0;
    logic [31:0] i_new_y = '0;
    logic [31:0] i_new_heading = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [31:0] o_pos_x;
    logic [31:0] o_pos_y;
    logic [30:0] o_heading;
    logic [31:0] o_twist_linear;
    logic [31:0] o_twist_angular;
    logic        o_step_accepted;

    // Predicted pose state and threshold.
    logic [31:0]  model_x, model_y, model_heading, model_lin, model_ang;
    logic [15:0]  model_threshold;
    pose_report_t pending_reports[$];
    int           error_count = 0;
    bit           calm = 1'b0;
    int           stall_cycles = 0;
    int           hold_requests = 0;
    int           hold_served = 0;

    planar_pose_arc_integrator_core u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_operation     (i_operation),
        .i_linear_speed  (i_linear_speed),
        .i_angular_rate  (i_angular_rate),
        .i_step_time     (i_step_time),
        .i_new_x         (i_new_x),
        .i_new_y         (i_new_y),
        .i_new_heading   (i_new_heading),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_pos_x         (o_pos_x),
        .o_pos_y         (o_pos_y),
        .o_heading       (o_heading),
        .o_twist_linear  (o_twist_linear),
        .o_twist_angular (o_twist_angular),
        .o_step_accepted (o_step_accepted)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("FAIL planar_pose_arc_integrator_core");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Fixed-point predictor
    // ------------------------------------------------------------------------
    function automatic longint sext32(logic [31:0] v);
        return longint'(signed'(v));
    endfunction

    function automatic longint round_shift(longint v, int n);
        return (v + (64'sd1 <<< (n - 1))) >>> n;
    endfunction

    // Fold an angle into (-pi, pi] using a truncating remainder.
    function automatic longint fold_angle(longint a);
        longint two_pi;
        longint r;
        two_pi = longint'(TWO_PI_Q);
        r = (a + longint'(PI_Q)) % two_pi;
        if (r <= 0) r += two_pi;
        return r - longint'(PI_Q);
    endfunction

    // Rotation-mode CORDIC giving cosine and sine in Q2.30.
    task automatic rotate_unit(input longint a, output longint c, output longint s);
        longint arctan[32] = '{210828714, 124459457, 67103136, 33381290, 16755422,
                               8385879, 4193963, 2097109, 1048571, 524287, 262144,
                               131072, 65536, 32768, 16384, 8192, 4096, 2048, 1024,
                               512, 256, 128, 64, 32, 16, 8, 4, 2, 1, 0, 0, 0};
        bit     flip;
        longint cx, cy, z, dx, dy;
        flip = 1'b0;
        if (a > longint'(HALF_PI_Q)) begin
            a -= longint'(PI_Q);
            flip = 1'b1;
        end else if (a < -longint'(HALF_PI_Q)) begin
            a += longint'(PI_Q);
            flip = 1'b1;
        end
        cx = longint'(CORDIC_GAIN_Q30);
        cy = 0;
        z  = a;
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            dx = cy >>> i;
            dy = cx >>> i;
            if (z >= 0) begin
                cx -= dx; cy += dy; z -= arctan[i];
            end else begin
                cx += dx; cy -= dy; z += arctan[i];
            end
        end
        c = flip ? -cx : cx;
        s = flip ? -cy : cy;
    endtask

    // Advance the predicted pose by one request and queue the report.
    task automatic predict_pose(input odo_request_t req);
        longint       v, w, dt, h0, h1, aw, c0, s0, c1, s1, travel;
        logic [63:0]  prod;
        pose_report_t rep;
        rep.step_accepted = 1'b0;
        if (req.operation == OP_SET_POSE) begin
            model_x       = req.new_x;
            model_y       = req.new_y;
            model_heading = 32'(fold_angle(sext32(req.new_heading)));
        end else begin
            v  = sext32(req.linear_speed);
            w  = sext32(req.angular_rate);
            dt = sext32(req.step_time);
            if (dt > 0) begin
                h0 = sext32(model_heading);
                h1 = fold_angle(h0 + round_shift(w * dt, 4));
                aw = (w < 0) ? -w : w;
                rotate_unit(h0, c0, s0);
                if (w == 0 || aw < longint'(model_threshold)) begin
                    // Straight motion along the current heading.
                    travel = round_shift(v * dt, 16);
                    prod = travel * c0 + 64'd536870912;
                    model_x += prod[61:30];
                    prod = travel * s0 + 64'd536870912;
                    model_y += prod[61:30];
                end else begin
                    // Constant-curvature arc of radius v / w.
                    rotate_unit(h1, c1, s1);
                    model_x += 32'(round_shift((v * (s1 - s0)) / w, 14));
                    model_y -= 32'(round_shift((v * (c1 - c0)) / w, 14));
                end
                model_heading = 32'(h1);
                model_lin     = req.linear_speed;
                model_ang     = req.angular_rate;
                rep.step_accepted = 1'b1;
            end
        end
        rep.pos_x         = model_x;
        rep.pos_y         = model_y;
        rep.heading       = model_heading[30:0];
        rep.twist_linear  = model_lin;
        rep.twist_angular = model_ang;
        pending_reports.push_back(rep);
    endtask

    // ------------------------------------------------------------------------
    // Result side: checking.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        pose_report_t want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_reports.size() == 0) begin
                $display("%0t: unexpected result x=%h y=%h", $time, o_pos_x, o_pos_y);
                error_count++;
            end else begin
                want = pending_reports.pop_front();
                if (o_pos_x !== want.pos_x) begin
                    $display("%0t: pos_x exp %h got %h", $time, want.pos_x, o_pos_x);
                    error_count++;
                end
                if (o_pos_y !== want.pos_y) begin
                    $display("%0t: pos_y exp %h got %h", $time, want.pos_y, o_pos_y);
                    error_count++;
                end
                if (o_heading !== want.heading) begin
                    $display("%0t: heading exp %h got %h", $time, want.heading, o_heading);
                    error_count++;
                end
                if (o_twist_linear !== want.twist_linear) begin
                    $display("%0t: twist_linear exp %h got %h", $time,
                             want.twist_linear, o_twist_linear);
                    error_count++;
                end
                if (o_twist_angular !== want.twist_angular) begin
                    $display("%0t: twist_angular exp %h got %h", $time,
                             want.twist_angular, o_twist_angular);
                    error_count++;
                end
                if (o_step_accepted !== want.step_accepted) begin
                    $display("%0t: step_accepted exp %b got %b", $time,
                             want.step_accepted, o_step_accepted);
                    error_count++;
                end
            end
        end
    end

    // Result side ready: random stalls, and long hold-offs counted here.
    always @(posedge i_clk) begin
        if (hold_served != hold_requests) begin
            hold_served  <= hold_requests;
            stall_cycles <= HOLD_CYCLES;
            i_out_ready  <= 1'b0;
        end else if (stall_cycles > 0) begin
            stall_cycles <= stall_cycles - 1;
            i_out_ready  <= 1'b0;
        end else begin
            i_out_ready <= calm || ($urandom_range(99) >= 12);
        end
    end

    // ------------------------------------------------------------------------
    // Request side helpers
    // ------------------------------------------------------------------------
    // Offer one request, sometimes after a random gap, and hold it until taken.
    task automatic send_request(input odo_request_t req);
        if (!calm && $urandom_range(99) < 12) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_operation    <= req.operation;
        i_linear_speed <= req.linear_speed;
        i_angular_rate <= req.angular_rate;
        i_step_time    <= req.step_time;
        i_new_x        <= req.new_x;
        i_new_y        <= req.new_y;
        i_new_heading  <= req.new_heading;
        do @(posedge i_clk); while (!o_in_ready);
        predict_pose(req);
    endtask

    // Stop offering and wait until every result is in and the block is idle.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_reports.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_threshold(input logic [15:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        model_threshold = value;
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic odo_request_t step_req(logic [31:0] v, logic [31:0] w,
                                              logic [31:0] dt);
        odo_request_t r;
        r = '{OP_STEP, v, w, dt, $urandom, $urandom, $urandom};
        return r;
    endfunction

    function automatic odo_request_t pose_req(logic [31:0] px, logic [31:0] py,
                                              logic [31:0] ph);
        odo_request_t r;
        r = '{OP_SET_POSE, $urandom, $urandom, $urandom, px, py, ph};
        return r;
    endfunction

    // Mostly plausible odometry, with full-range noise mixed in.
    function automatic odo_request_t random_req(logic [15:0] thr);
        logic [31:0] v, w, dt;
        if ($urandom_range(99) < 10)
            return pose_req($urandom, $urandom, $urandom);
        case ($urandom_range(3))
            0:       v = $urandom;
            1:       v = $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
            default: v = $urandom_range(0, 32'h0002_0000) - 32'h0001_0000;
        endcase
        case ($urandom_range(4))
            0:       w = $urandom;
            1:       w = $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
            2:       w = 32'(thr) + $urandom_range(0, 4) - 2;
            3:       w = -(32'(thr) + $urandom_range(0, 4) - 2);
            default: w = $urandom_range(0, 32'h0000_1000) - 32'h0000_0800;
        endcase
        case ($urandom_range(9))
            0:       dt = $urandom;
            1:       dt = '0;
            2:       dt = $urandom_range(0, 32'h0010_0000);
            default: dt = $urandom_range(1, 32'h0000_2000);
        endcase
        return step_req(v, w, dt);
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    // Field extremes, rejected steps, zero yaw rate and heading folding.
    task automatic test_directed();
        send_request(step_req(32'h0001_0000, 32'h0000_1000, 32'h0000_0000));
        send_request(step_req(32'h0001_0000, 32'h0000_1000, 32'h8000_0000));
        send_request(step_req(32'h0001_0000, 32'h0001_0000, 32'hFFFF_FFFF));
        send_request(step_req(32'h0002_0000, 32'h0000_0000, 32'h0000_1000));
        send_request(step_req(32'h0001_0000, 32'h0001_0000, 32'h0000_4000));
        send_request(step_req(32'hFFFF_0000, 32'hFFFF_0000, 32'h0000_4000));
        send_request(pose_req(32'h7FFF_FFFF, 32'h8000_0000, PI_Q));
        send_request(pose_req(32'h8000_0000, 32'h7FFF_FFFF, -PI_Q));
        send_request(pose_req('0, '0, 32'h7FFF_FFFF));
        send_request(step_req(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF));
        send_request(pose_req('0, '0, 32'h8000_0000));
        send_request(step_req(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001));
        send_request(step_req(32'h7FFF_FFFF, 32'h0000_0000, 32'h7FFF_FFFF));
        send_request(step_req(32'h8000_0000, 32'h0000_0001, 32'h0001_0000));
        send_request(pose_req(32'hFFFF_FFFF, 32'h0000_0001, HALF_PI_Q));
        send_request(step_req(32'h0003_0000, 32'h0003_0000, 32'h0000_8000));
        drain_results();
        // A zero threshold still keeps zero yaw rate on the straight form.
        write_threshold(16'd0);
        send_request(step_req(32'h0001_0000, 32'h0000_0000, 32'h0001_0000));
        send_request(step_req(32'h0001_0000, 32'h0000_0001, 32'h0001_0000));
        send_request(step_req(32'h0001_0000, 32'hFFFF_FFFF, 32'h0001_0000));
        drain_results();
    endtask

    // Random traffic under a given threshold.
    task automatic test_random_phase(input logic [15:0] thr, input int count);
        write_threshold(thr);
        for (int k = 0; k < count; k++) send_request(random_req(thr));
        drain_results();
    endtask

    // Hold the result side off while requests keep coming, so the block stalls.
    task automatic test_backpressure();
        hold_requests++;
        for (int k = 0; k < 12; k++) send_request(random_req(model_threshold));
        drain_results();
    endtask

    // A phase with no idling on either side.
    task automatic test_no_idle();
        calm = 1'b1;
        for (int k = 0; k < 120; k++) send_request(random_req(model_threshold));
        drain_results();
        calm = 1'b0;
    endtask

    initial begin
        model_x = '0; model_y = '0; model_heading = '0;
        model_lin = '0; model_ang = '0;
        model_threshold = THRESHOLD_RESET;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random_phase(16'd1, 200);
        test_random_phase(16'd65535, 150);
        test_backpressure();
        test_random_phase(16'($urandom), 150);
        test_no_idle();
        test_random_phase(16'd0, 100);
        test_random_phase(16'h0400, 150);

        if (error_count == 0) begin
            $display("PASS planar_pose_arc_integrator_core");
        end else begin
            $display("FAIL planar_pose_arc_integrator_core");
        end
        $finish;
    end

endmodule

`default_nettype wire

@@ filelist.f @@
src/ppai_pkg.sv
src/ppai_mul.sv
src/ppai_div.sv
src/ppai_wrap.sv
src/ppai_cordic.sv
src/planar_pose_arc_integrator_core.sv
sim/tb_planar_pose_arc_integrator_core.sv
